/* hdl/tcgr_pkg.sv */
// Shared types and constants for the text console glyph renderer.
// Used by every module of the block; depends on nothing.
package tcgr_pkg;

    // Character grid and glyph geometry
    localparam int COL_BITS         = 7;
    localparam int TEXT_COLS        = 128;
    localparam int ROW_BITS         = 6;
    localparam int TEXT_ROWS        = 48;
    localparam int GLYPH_ROW_BITS   = 4;
    localparam int GLYPH_HEIGHT     = 16;
    localparam int GLYPH_WIDTH_BITS = 3;
    localparam int OFF_BITS         = 13;
    localparam int QUOT_BITS        = OFF_BITS - COL_BITS;

    // Payload widths
    localparam int CODE_W   = 8;
    localparam int COLOR_W  = 24;
    localparam int GADDR_W  = 12;
    localparam int PIX_W    = 10;
    localparam int CPOS_W   = 14;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Character codes
    localparam logic [CODE_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [CODE_W-1:0] CH_RETURN     = 8'h0D;
    localparam logic [CODE_W-1:0] CH_BACKSPACE  = 8'h08;
    localparam logic [CODE_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CODE_W-1:0] CH_UNDERSCORE = 8'h5F;

    localparam logic [COLOR_W-1:0] CURSOR_COLOR = 24'h00FF00;

    typedef enum logic [1:0] {
        ACT_PRINT      = 2'd0,
        ACT_LOAD       = 2'd1,
        ACT_SET_CURSOR = 2'd2
    } t_action;

    // One queued job for the back end: a glyph memory write or a print
    typedef struct packed {
        logic                      is_load;
        logic                      has_char;
        logic [CODE_W-1:0]         code;
        logic [COLOR_W-1:0]        color;
        logic [GADDR_W-1:0]        glyph_addr;
        logic [7:0]                glyph_byte;
        logic [COL_BITS-1:0]       old_col;
        logic [ROW_BITS-1:0]       old_row;
        logic [COL_BITS-1:0]       new_col;
        logic [ROW_BITS-1:0]       new_row;
    } t_entry;

endpackage

/* hdl/tcgr_front.sv */
// Front end: accepts input words, keeps the text cursor, queues back-end jobs.
// Depends on tcgr_pkg.
module tcgr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [tcgr_pkg::CODE_W-1:0]   i_char_code,
    input  logic [tcgr_pkg::COLOR_W-1:0]  i_draw_color,
    input  logic [tcgr_pkg::GADDR_W-1:0]  i_glyph_address,
    input  logic [7:0]                    i_glyph_byte,
    input  logic [tcgr_pkg::CPOS_W-1:0]   i_text_offset,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output tcgr_pkg::t_entry              o_entry
);
    import tcgr_pkg::*;

    logic [COL_BITS-1:0]  r_col;
    logic [ROW_BITS-1:0]  r_row;

    logic                 w_accept;
    logic [COL_BITS:0]    w_p_col;
    logic [ROW_BITS:0]    w_p_row;
    logic                 w_has_char;
    logic [CODE_W-1:0]    w_code;
    logic [OFF_BITS-1:0]  w_off;
    logic [QUOT_BITS-1:0] w_quot;
    logic [QUOT_BITS-1:0] w_quot_wrap;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && ((i_action == ACT_PRINT) || (i_action == ACT_LOAD));

    // Cursor after a print
    always_comb begin
        w_p_col    = {1'b0, r_col};
        w_p_row    = {1'b0, r_row};
        w_has_char = 1'b1;
        w_code     = i_char_code;
        unique case (i_char_code)
            CH_NEWLINE: begin
                w_p_col    = '0;
                w_p_row    = {1'b0, r_row} + 1'b1;
                w_has_char = 1'b0;
            end
            CH_RETURN: begin
                w_p_col    = '0;
                w_has_char = 1'b0;
            end
            CH_BACKSPACE: begin
                w_code = CH_SPACE;
            end
            default: begin
                w_p_col = {1'b0, r_col} + 1'b1;
            end
        endcase
        if (w_p_col >= (COL_BITS+1)'(TEXT_COLS)) begin
            w_p_col = '0;
            w_p_row = w_p_row + 1'b1;
        end
        if (w_p_row >= (ROW_BITS+1)'(TEXT_ROWS)) begin
            w_p_row = '0;
        end
    end

    // Set cursor: halve, split into row and column, wrap the row once
    assign w_off       = i_text_offset[CPOS_W-1:1];
    assign w_quot      = w_off[OFF_BITS-1:COL_BITS];
    assign w_quot_wrap = (w_quot >= QUOT_BITS'(TEXT_ROWS)) ?
                         w_quot - QUOT_BITS'(TEXT_ROWS) : w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (i_action == ACT_PRINT) begin
                r_col <= w_p_col[COL_BITS-1:0];
                r_row <= w_p_row[ROW_BITS-1:0];
            end else if (i_action == ACT_SET_CURSOR) begin
                r_col <= w_off[COL_BITS-1:0];
                r_row <= ROW_BITS'(w_quot_wrap);
            end
        end
    end

    always_comb begin
        o_entry            = '0;
        o_entry.is_load    = (i_action == ACT_LOAD);
        o_entry.has_char   = w_has_char;
        o_entry.code       = w_code;
        o_entry.color      = i_draw_color;
        o_entry.glyph_addr = i_glyph_address;
        o_entry.glyph_byte = i_glyph_byte;
        o_entry.old_col    = r_col;
        o_entry.old_row    = r_row;
        o_entry.new_col    = w_p_col[COL_BITS-1:0];
        o_entry.new_row    = w_p_row[ROW_BITS-1:0];
    end

endmodule

/* hdl/tcgr_queue.sv */
// Small job queue between front end and back end.
// Depends on tcgr_pkg for the entry type.
module tcgr_queue #(
    parameter int DEPTH = tcgr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tcgr_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output tcgr_pkg::t_entry  o_entry,
    output logic              o_empty,
    output logic              o_full
);
    import tcgr_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_entry              r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* hdl/tcgr_back.sv */
// Back end: glyph memory, row sequencer and output register stage.
// Depends on tcgr_pkg; takes jobs from tcgr_queue.
module tcgr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  tcgr_pkg::t_entry              i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tcgr_pkg::PIX_W-1:0]    o_pixel_x,
    output logic [tcgr_pkg::PIX_W-1:0]    o_pixel_y,
    output logic [7:0]                    o_row_mask,
    output logic [tcgr_pkg::COLOR_W-1:0]  o_pixel_color,
    output logic                          o_final_write,
    output logic [tcgr_pkg::CPOS_W-1:0]   o_cursor_position
);
    import tcgr_pkg::*;

    localparam int MEM_DEPTH = 1 << GADDR_W;

    logic [7:0]                r_glyph_mem [MEM_DEPTH];
    logic [7:0]                r_rdata;

    // Sequencer state
    logic                      r_underline;
    logic [GLYPH_ROW_BITS-1:0] r_grow;

    // Read stage
    logic                      r_s1_valid;
    logic [PIX_W-1:0]          r_s1_x;
    logic [PIX_W-1:0]          r_s1_y;
    logic [COLOR_W-1:0]        r_s1_color;
    logic                      r_s1_final;
    logic [CPOS_W-1:0]         r_s1_cpos;

    // Output stage
    logic                      r_out_valid;

    logic                      w_s1_adv;
    logic                      w_issue_ok;
    logic                      w_op;
    logic                      w_draw;
    logic                      w_uline;
    logic                      w_last_row;
    logic [GADDR_W-1:0]        w_rd_addr;
    logic [COL_BITS-1:0]       w_col;
    logic [ROW_BITS-1:0]       w_row;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_ready);
    assign w_issue_ok = !r_s1_valid || w_s1_adv;
    assign w_op       = i_job_valid && w_issue_ok;
    assign w_draw     = w_op && !i_job.is_load;
    assign w_uline    = r_underline || !i_job.has_char;
    assign w_last_row = (r_grow == GLYPH_ROW_BITS'(GLYPH_HEIGHT - 1));
    assign o_pop      = w_op && (i_job.is_load || (w_uline && w_last_row));

    assign w_rd_addr = w_uline ? {CH_UNDERSCORE, r_grow} : {i_job.code, r_grow};
    assign w_col     = w_uline ? i_job.new_col : i_job.old_col;
    assign w_row     = w_uline ? i_job.new_row : i_job.old_row;

    // Glyph memory: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_op && i_job.is_load) begin
            r_glyph_mem[i_job.glyph_addr] <= i_job.glyph_byte;
        end
        if (w_draw) begin
            r_rdata <= r_glyph_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_underline <= 1'b0;
            r_grow      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_draw) begin
                if (w_last_row) begin
                    r_grow      <= '0;
                    r_underline <= !w_uline;
                end else begin
                    r_grow <= r_grow + 1'b1;
                end
            end
            if (w_draw) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_s1_x     <= {w_col, GLYPH_WIDTH_BITS'(0)};
            r_s1_y     <= PIX_W'(PIX_W'(w_row) * PIX_W'(GLYPH_HEIGHT) + PIX_W'(r_grow));
            r_s1_color <= w_uline ? CURSOR_COLOR : i_job.color;
            r_s1_final <= w_uline && w_last_row;
            r_s1_cpos  <= {i_job.new_row, i_job.new_col, 1'b0};
        end
        if (w_s1_adv) begin
            o_pixel_x         <= r_s1_x;
            o_pixel_y         <= r_s1_y;
            o_row_mask        <= r_rdata;
            o_pixel_color     <= r_s1_color;
            o_final_write     <= r_s1_final;
            o_cursor_position <= r_s1_cpos;
        end
    end

    assign o_valid = r_out_valid;

endmodule

/* hdl/text_console_glyph_renderer.sv */
// Text console glyph renderer, top level.
// Depends on tcgr_pkg, tcgr_front, tcgr_queue and tcgr_back.
//
// Usage:
//   Input words arrive on s_axis; tuser carries the action (print, load a
//   glyph memory byte, set the cursor offset). A print word turns into
//   16 glyph-row writes for the character (skipped for newline and return)
//   and then 16 rows of a green underscore cursor at the new position.
//   Each row write leaves on m_axis; tlast marks the final row of a print.
//   Load and set-cursor words produce no output word.
// The first row write of a print passes the job queue, the read stage and the output stage.
// The back end issues one glyph memory read per cycle while jobs are queued and
//   m_axis_tready does not stall it; a load does not read and produces no output,
//   and set-cursor words are absorbed by the front end.
// The front end runs ahead of the back end by up to QUEUE_DEPTH jobs;
//   s_axis_tready drops only while that queue is full.
// Reset (i_rst_n low, synchronous): cursor goes to row 0, column 0, queue
//   and pipeline empty. The glyph memory is not cleared: load every glyph
//   before printing it, including space and underscore.
// When m_axis_tready is low, the output word holds and the back end stalls;
//   the front end keeps accepting until the queue fills.
module text_console_glyph_renderer #(
    parameter int QUEUE_DEPTH = tcgr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], draw_color[31:8], glyph_address[43:32],
    // glyph_byte[51:44], text_offset[65:52], zero fill [71:66]
    input  logic [71:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_x[9:0], pixel_y[19:10], row_mask[27:20], pixel_color[51:28],
    // cursor_position[65:52], zero fill [71:66]
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import tcgr_pkg::*;

    t_entry               w_push_entry;
    t_entry               w_head_entry;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_queue_empty;
    logic                 w_queue_full;

    logic [PIX_W-1:0]     w_pixel_x;
    logic [PIX_W-1:0]     w_pixel_y;
    logic [7:0]           w_row_mask;
    logic [COLOR_W-1:0]   w_pixel_color;
    logic [CPOS_W-1:0]    w_cursor_position;

    // Classify words and track the cursor
    tcgr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_action        (s_axis_tuser),
        .i_char_code     (s_axis_tdata[7:0]),
        .i_draw_color    (s_axis_tdata[31:8]),
        .i_glyph_address (s_axis_tdata[43:32]),
        .i_glyph_byte    (s_axis_tdata[51:44]),
        .i_text_offset   (s_axis_tdata[65:52]),
        .i_queue_full    (w_queue_full),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    // Decouple cursor tracking from row generation
    tcgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_empty (w_queue_empty),
        .o_full  (w_queue_full)
    );

    // Glyph memory and row writes
    tcgr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (!w_queue_empty),
        .i_job             (w_head_entry),
        .o_pop             (w_pop),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_pixel_x         (w_pixel_x),
        .o_pixel_y         (w_pixel_y),
        .o_row_mask        (w_row_mask),
        .o_pixel_color     (w_pixel_color),
        .o_final_write     (m_axis_tlast),
        .o_cursor_position (w_cursor_position)
    );

    assign m_axis_tdata = {6'b0, w_cursor_position, w_pixel_color, w_row_mask,
                           w_pixel_y, w_pixel_x};

    // The last row of a print is always the cursor underscore
    a_last_is_cursor_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> w_pixel_color == CURSOR_COLOR)
        else $error("final row write not in cursor color");

    // The last row lands on the bottom glyph row at the reported cursor cell
    a_last_at_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            w_pixel_x[9:3] == w_cursor_position[7:1] &&
            w_pixel_y[9:4] == w_cursor_position[13:8] &&
            w_pixel_y[3:0] == 4'hF)
        else $error("final row write not at cursor cell");

    // The back end retires only jobs that are present
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_queue_empty)
        else $error("job queue popped while empty");

endmodule

/* bench/text_console_glyph_renderer_test.sv */
// Self-checking bench for text_console_glyph_renderer: clocked driver and monitor,
// with a glyph-row predictor that checks every output word in order.
// Depends on tcgr_pkg and the renderer RTL only.
module text_console_glyph_renderer_test;
    import tcgr_pkg::*;

    // Action code that the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Hard stop for a hung run, in time units
    localparam int RUN_LIMIT = 2_000_000;
    // Cycles the receiver holds off in the back-pressure test
    localparam int LONG_STALL = 300;
    // Random words per phase (ignored words are extra)
    localparam int PHASE_WORDS = 22;

    // One input word as the bench sees it
    typedef struct {
        logic [1:0]         action;
        logic [CODE_W-1:0]  code;
        logic [COLOR_W-1:0] color;
        logic [GADDR_W-1:0] gaddr;
        logic [7:0]         gbyte;
        logic [CPOS_W-1:0]  offset;
    } t_console_word;

    // One glyph-row write as it should leave the block
    typedef struct {
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic [7:0]         mask;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic [CPOS_W-1:0]  cpos;
    } t_row_write;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // char_code[7:0], draw_color[31:8], glyph_address[43:32],
    // glyph_byte[51:44], text_offset[65:52], zero fill [71:66]
    logic [71:0] s_axis_tdata = '0;
    // action[1:0]
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // pixel_x[9:0], pixel_y[19:10], row_mask[27:20], pixel_color[51:28],
    // cursor_position[65:52], zero fill [71:66]
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    text_console_glyph_renderer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Stimulus side: words waiting for the driver, the word on the bus
    t_console_word words_to_send[$];
    t_console_word word_on_bus;
    bit            word_taken = 1'b0;
    int            n_queued = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            stall_left = 0;

    // Generator knowledge of which glyphs are fully loaded; never print any other
    bit                glyph_ready [256];
    logic [CODE_W-1:0] ready_codes[$];

    // Predictor state: its own cursor and glyph memory
    int         cur_col = 0;
    int         cur_row = 0;
    logic [7:0] glyph_mem [4096];
    t_row_write step_rows[$];
    t_row_write rows_due[$];

    // Run statistics
    int n_taken = 0;
    int n_prints = 0;
    int n_loads = 0;
    int n_sets = 0;
    int n_rows_checked = 0;
    int n_held = 0;
    int n_errors = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Append the GLYPH_HEIGHT row writes of one glyph at the current cursor
    task automatic add_glyph_rows(input logic [CODE_W-1:0] code,
                                  input logic [COLOR_W-1:0] color);
        t_row_write r;
        for (int j = 0; j < GLYPH_HEIGHT; j++) begin
            r.px    = PIX_W'(cur_col * 8);
            r.py    = PIX_W'(cur_row * GLYPH_HEIGHT + j);
            r.mask  = glyph_mem[code * 16 + j];
            r.color = color;
            r.last  = 1'b0;
            r.cpos  = '0;
            step_rows.push_back(r);
        end
    endtask

    // Apply one accepted word to the predicted state; queue the rows it causes
    task automatic render_word(input t_console_word w);
        int         off;
        int         col_next;
        int         row_next;
        t_row_write r;
        case (w.action)
            ACT_LOAD: begin
                glyph_mem[w.gaddr] = w.gbyte;
                n_loads++;
            end
            ACT_SET_CURSOR: begin
                // the offset is doubled; an out-of-range row wraps around
                off = w.offset / 2;
                cur_row = (off / TEXT_COLS) % TEXT_ROWS;
                cur_col = off % TEXT_COLS;
                n_sets++;
            end
            ACT_PRINT: begin
                n_prints++;
                col_next = cur_col;
                row_next = cur_row;
                if (w.code == CH_NEWLINE) begin
                    col_next = 0;
                    row_next++;
                end else if (w.code == CH_RETURN) begin
                    col_next = 0;
                end else if (w.code == CH_BACKSPACE) begin
                    // blank the cell in place, cursor stays
                    add_glyph_rows(CH_SPACE, w.color);
                end else begin
                    add_glyph_rows(w.code, w.color);
                    col_next++;
                end
                if (col_next >= TEXT_COLS) begin
                    col_next = 0;
                    row_next++;
                end
                if (row_next >= TEXT_ROWS) row_next = 0;
                cur_col = col_next;
                cur_row = row_next;
                add_glyph_rows(CH_UNDERSCORE, CURSOR_COLOR);
                // every row of the step carries the new cursor; mark the final one
                while (step_rows.size() != 0) begin
                    r = step_rows.pop_front();
                    r.cpos = CPOS_W'((cur_row * TEXT_COLS + cur_col) * 2);
                    r.last = (step_rows.size() == 0);
                    rows_due.push_back(r);
                end
            end
            default: ;  // unused action: no effect at all
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    task automatic check_row();
        t_row_write exp_r;
        if (rows_due.size() == 0) begin
            $display("%0t: unexpected row write, expected none, actual tdata %h",
                     $time, m_axis_tdata);
            n_errors++;
        end else begin
            exp_r = rows_due.pop_front();
            check_field("pixel_x", exp_r.px, m_axis_tdata[9:0]);
            check_field("pixel_y", exp_r.py, m_axis_tdata[19:10]);
            check_field("row_mask", exp_r.mask, m_axis_tdata[27:20]);
            check_field("pixel_color", exp_r.color, m_axis_tdata[51:28]);
            check_field("cursor_position", exp_r.cpos, m_axis_tdata[65:52]);
            check_field("final_write", exp_r.last, m_axis_tlast);
            n_rows_checked++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------

    // Drive on the falling edge: hold a word until taken, then fetch the next
    // one or idle at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                word_on_bus = words_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'b0, word_on_bus.offset, word_on_bus.gbyte,
                                  word_on_bus.gaddr, word_on_bus.color, word_on_bus.code};
                s_axis_tuser  <= word_on_bus.action;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or hold off completely during a long stall
    always @(negedge i_clk) begin
        m_axis_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Count the long stall down in its own process
    always @(posedge i_clk) begin
        if (stall_left > 0) stall_left--;
    end

    // Monitor: predict from each accepted input word, check each output word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                render_word(word_on_bus);
                n_taken++;
                word_taken = 1'b1;
            end
            if (s_axis_tvalid && !s_axis_tready) n_held++;
            if (m_axis_tvalid && m_axis_tready) check_row();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic t_console_word noise_word();
        t_console_word w;
        w.action = ACT_UNUSED;
        w.code   = CODE_W'($urandom);
        w.color  = COLOR_W'($urandom);
        w.gaddr  = GADDR_W'($urandom);
        w.gbyte  = 8'($urandom);
        w.offset = CPOS_W'($urandom);
        return w;
    endfunction

    task automatic queue_word(input t_console_word w);
        words_to_send.push_back(w);
        n_queued++;
    endtask

    task automatic queue_print(input logic [CODE_W-1:0] code,
                               input logic [COLOR_W-1:0] color);
        t_console_word w;
        w = noise_word();
        w.action = ACT_PRINT;
        w.code   = code;
        w.color  = color;
        queue_word(w);
    endtask

    task automatic queue_cursor(input int row, input int col);
        t_console_word w;
        w = noise_word();
        w.action = ACT_SET_CURSOR;
        w.offset = CPOS_W'((row * TEXT_COLS + col) * 2);
        queue_word(w);
    endtask

    // Load all 16 rows of a glyph with random bits
    task automatic load_glyph(input logic [CODE_W-1:0] code);
        t_console_word w;
        for (int j = 0; j < 16; j++) begin
            w = noise_word();
            w.action = ACT_LOAD;
            w.gaddr  = GADDR_W'(code * 16 + j);
            queue_word(w);
        end
        if (!glyph_ready[code]) ready_codes.push_back(code);
        glyph_ready[code] = 1'b1;
    endtask

    task automatic load_new_glyphs(input int count);
        logic [CODE_W-1:0] code;
        for (int k = 0; k < count; k++) begin
            do code = CODE_W'($urandom);
            while (glyph_ready[code] || code == CH_NEWLINE || code == CH_RETURN ||
                   code == CH_BACKSPACE);
            load_glyph(code);
        end
    endtask

    // Mostly prints of loaded glyphs, with control codes, cursor moves, stray
    // loads and the odd ignored word mixed in.
    task automatic queue_random_words(input int count);
        t_console_word w;
        int            made;
        int            pick;
        made = 0;
        while (made < count) begin
            w = noise_word();
            pick = $urandom_range(99);
            made++;
            if (pick < 55) begin
                w.action = ACT_PRINT;
                w.code = ready_codes[$urandom_range(ready_codes.size() - 1)];
            end else if (pick < 64) begin
                w.action = ACT_PRINT;
                case ($urandom_range(2))
                    0:       w.code = CH_NEWLINE;
                    1:       w.code = CH_RETURN;
                    default: w.code = CH_BACKSPACE;
                endcase
            end else if (pick < 72) begin
                // park near the end of a row so wraps come often
                w.action = ACT_SET_CURSOR;
                w.offset = CPOS_W'(($urandom_range(TEXT_ROWS - 1) * TEXT_COLS
                                    + $urandom_range(TEXT_COLS - 1, TEXT_COLS - 8)) * 2
                                   + $urandom_range(1));
            end else if (pick < 80) begin
                // any offset, out-of-range rows included
                w.action = ACT_SET_CURSOR;
            end else if (pick < 96) begin
                // stray load: writes only, never a read of a fresh entry
                w.action = ACT_LOAD;
            end else begin
                made--;  // ignored word, not counted
            end
            queue_word(w);
        end
    endtask

    // Hold the generator until every word is taken and every row has come out
    task automatic wait_all_rendered();
        while (n_taken != n_queued || rows_due.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_console_word w;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Phase one: slow receiver
        send_idle_pct = 9;
        recv_idle_pct = 74;

        // Space and underscore first: backspace and the cursor read them
        load_glyph(CH_SPACE);
        load_glyph(CH_UNDERSCORE);
        load_glyph(8'h00);
        load_glyph(8'hFF);
        load_glyph(8'h41);

        // Directed: field extremes, control codes, wraps
        queue_print(8'h41, 24'hFFFFFF);
        queue_print(8'h00, 24'h000000);
        queue_print(8'hFF, COLOR_W'($urandom));
        queue_print(CH_NEWLINE, COLOR_W'($urandom));
        queue_print(CH_RETURN, COLOR_W'($urandom));
        queue_print(CH_BACKSPACE, COLOR_W'($urandom));
        // last cell of the grid: column and row both wrap to the origin
        queue_cursor(TEXT_ROWS - 1, TEXT_COLS - 1);
        queue_print(8'h41, COLOR_W'($urandom));
        // newline on the bottom row goes back to row 0
        queue_cursor(TEXT_ROWS - 1, 5);
        queue_print(CH_NEWLINE, COLOR_W'($urandom));
        // offset beyond the grid: the row wraps around
        w = noise_word();
        w.action = ACT_SET_CURSOR;
        w.offset = '1;
        queue_word(w);
        queue_print(8'hFF, COLOR_W'($urandom));
        // odd offset: the low bit is dropped
        w = noise_word();
        w.action = ACT_SET_CURSOR;
        w.offset = 14'd1;
        queue_word(w);
        queue_print(8'h00, COLOR_W'($urandom));
        // ignored action with every field high
        w.action = ACT_UNUSED;
        w.code   = '1;
        w.color  = '1;
        w.gaddr  = '1;
        w.gbyte  = '1;
        w.offset = '1;
        queue_word(w);
        // control codes in the last column
        queue_cursor(3, TEXT_COLS - 1);
        queue_print(CH_RETURN, COLOR_W'($urandom));
        queue_cursor(3, TEXT_COLS - 1);
        queue_print(CH_BACKSPACE, COLOR_W'($urandom));
        queue_cursor(10, TEXT_COLS - 1);
        queue_print(CH_NEWLINE, COLOR_W'($urandom));

        load_new_glyphs(2);
        queue_random_words(PHASE_WORDS);
        wait_all_rendered();

        // Phase two: slow sender
        send_idle_pct = 74;
        recv_idle_pct = 9;
        queue_random_words(PHASE_WORDS);
        wait_all_rendered();

        // Phase three: no idling; first fill the block against a stalled receiver
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_all_rendered();
        stall_left = LONG_STALL;
        for (int k = 0; k < 8; k++)
            queue_print(ready_codes[$urandom_range(ready_codes.size() - 1)],
                        COLOR_W'($urandom));
        queue_random_words(PHASE_WORDS / 2);
        // pause the sender until the block has drained completely
        wait_all_rendered();
        queue_random_words(PHASE_WORDS - PHASE_WORDS / 2);
        wait_all_rendered();

        // Let any stray output show up before the verdict
        repeat (40) @(negedge i_clk);

        $display("Covered %0d prints, %0d glyph loads, %0d cursor moves; %0d row writes checked",
                 n_prints, n_loads, n_sets, n_rows_checked);
        $display("Input held off by the block for %0d cycles; %0d mismatches",
                 n_held, n_errors);
        if (n_errors == 0 && rows_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
